// ===== src/tlpm_pkg.sv =====
// ----------------------------------------------------------------------------
// tlpm_pkg: shared types and constants of the tank level phase monitor
// Holds the phase codes, the configuration register indexes, the queue item
// and configuration bundles, and the fixed field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package tlpm_pkg;

    // Fixed field widths
    localparam int RAW_W     = 12;
    localparam int CFG_W     = 10;
    localparam int LEVEL_W   = 10;
    localparam int PHASE_W   = 3;
    localparam int PCT_W     = 17;
    localparam int ERR_W     = 8;
    localparam int CFG_IDX_W = 3;

    // Default block length and queue depth
    localparam int BLOCK_SAMPLES_DEF = 10;
    localparam int QUEUE_DEPTH_DEF   = 2;

    // Arithmetic constants
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 10'd999;
    localparam logic [6:0]         PCT_SCALE = 7'd100;
    localparam logic [ERR_W-1:0]   ERR_MAX   = 8'd255;
    localparam logic [ERR_W-1:0]   ERR_LIMIT = 8'd2;

    // Treatment phase codes
    typedef enum logic [PHASE_W-1:0] {
        PH_CIRC        = 3'd0,
        PH_AIR         = 3'd1,
        PH_ZONE        = 3'd2,
        PH_PUMP_OFF    = 3'd3,
        PH_MUD         = 3'd4,
        PH_MANUAL_CIRC = 3'd5,
        PH_OTHER       = 3'd6,
        PH_SET_DOWN    = 3'd7
    } phase_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CAL_OFFSET    = 3'd0,
        REG_O2_HEIGHT     = 3'd1,
        REG_CIRC_HEIGHT   = 3'd2,
        REG_MIN_PRESSURE  = 3'd3,
        REG_SENSOR_ENABLE = 3'd4
    } cfg_index_t;

    // Back-end sequencer states
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_OUT
    } back_state_t;

    // Configuration bundle
    typedef struct packed {
        logic [CFG_W-1:0] cal_offset;
        logic [CFG_W-1:0] o2_height;
        logic [CFG_W-1:0] circ_height;
        logic [CFG_W-1:0] min_pressure;
        logic             sensor_enable;
    } cfg_t;

    // Work item passed from front to back
    typedef struct packed {
        logic               is_clear;
        logic [LEVEL_W-1:0] level;
        phase_t             phase;
    } item_t;

endpackage

`default_nettype wire

// ===== src/tlpm_front.sv =====
// ----------------------------------------------------------------------------
// tlpm_front: sample intake and block averaging
// Calibrates and clamps each sample, accumulates the block sum and, at the
// end of a block, turns the sum into a level and queues it for the back end.
// Clear items are queued as markers so the back end sees them in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tlpm_front #(
    parameter int BLOCK_SAMPLES = tlpm_pkg::BLOCK_SAMPLES_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic                              s_func,
    input  wire logic [tlpm_pkg::RAW_W-1:0]        s_raw,
    input  wire logic [tlpm_pkg::PHASE_W-1:0]      s_phase,
    input  wire logic [tlpm_pkg::CFG_W-1:0]        cal_offset,
    output logic                                   push_valid,
    input  wire logic                              push_ready,
    output tlpm_pkg::item_t                        push_item
);

    localparam int CFG_W_LOCAL = tlpm_pkg::CFG_W;
    localparam int CNT_W    = $clog2(BLOCK_SAMPLES + 1);
    localparam int SUM_W    = $clog2(BLOCK_SAMPLES * 999 + 1);
    localparam int DIV_SH   = $clog2(BLOCK_SAMPLES);
    localparam int SHIFT    = SUM_W + DIV_SH;
    localparam int RECIP_W  = SUM_W + 1;
    localparam int PROD_W   = SUM_W + RECIP_W;
    localparam int QUOT_W   = PROD_W - SHIFT;
    // ceil(2^SHIFT / BLOCK_SAMPLES): exact quotient for every sum below 2^SUM_W
    localparam longint RECIP_L = ((64'd1 << SHIFT) + BLOCK_SAMPLES - 1) / BLOCK_SAMPLES;
    localparam logic [RECIP_W-1:0] RECIP     = RECIP_W'(RECIP_L);
    localparam logic [CNT_W-1:0]   CNT_LAST  = CNT_W'(BLOCK_SAMPLES - 1);

    logic [CNT_W-1:0]          count_reg, count_next;
    logic [SUM_W-1:0]          sum_reg, sum_next;
    logic                      pend_reg, pend_next;
    tlpm_pkg::phase_t          phase_reg, phase_next;

    logic                      accept;
    logic [CFG_W_LOCAL-1:0]    shifted;
    logic [CFG_W_LOCAL:0]      diff;
    logic [CFG_W_LOCAL-1:0]    cal_val;
    logic [PROD_W-1:0]         prod;
    logic [QUOT_W-1:0]         quot;
    logic [tlpm_pkg::LEVEL_W-1:0] level;

    assign s_ready = !pend_reg && push_ready;
    assign accept  = s_valid && s_ready;

    // Calibrate: drop two bits, subtract offset, clamp to 0..999
    always_comb begin
        shifted = s_raw[tlpm_pkg::RAW_W-1:2];
        diff    = {1'b0, shifted} - {1'b0, cal_offset};
        if (diff[CFG_W_LOCAL]) begin
            cal_val = '0;
        end else if (diff[CFG_W_LOCAL-1:0] > tlpm_pkg::LEVEL_MAX) begin
            cal_val = tlpm_pkg::LEVEL_MAX;
        end else begin
            cal_val = diff[CFG_W_LOCAL-1:0];
        end
    end

    // Block average by reciprocal multiply
    always_comb begin
        prod = PROD_W'(sum_reg) * PROD_W'(RECIP);
        quot = prod[PROD_W-1:SHIFT];
        if (quot > QUOT_W'(tlpm_pkg::LEVEL_MAX)) begin
            level = tlpm_pkg::LEVEL_MAX;
        end else begin
            level = quot[tlpm_pkg::LEVEL_W-1:0];
        end
    end

    // Queue push: a clear marker on accept, or a finished block
    always_comb begin
        push_valid         = pend_reg || (accept && s_func);
        push_item.is_clear = !pend_reg;
        push_item.level    = level;
        push_item.phase    = phase_reg;
    end

    // Counter and accumulator update
    always_comb begin
        count_next = count_reg;
        sum_next   = sum_reg;
        pend_next  = pend_reg;
        phase_next = phase_reg;
        if (pend_reg) begin
            if (push_ready) begin
                pend_next = 1'b0;
                sum_next  = '0;
            end
        end else if (accept) begin
            if (s_func) begin
                count_next = '0;
                sum_next   = '0;
            end else begin
                sum_next = sum_reg + SUM_W'(cal_val);
                if (count_reg == CNT_LAST) begin
                    count_next = '0;
                    pend_next  = 1'b1;
                    phase_next = tlpm_pkg::phase_t'(s_phase);
                end else begin
                    count_next = count_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            sum_reg   <= '0;
            pend_reg  <= 1'b0;
        end else begin
            count_reg <= count_next;
            sum_reg   <= sum_next;
            pend_reg  <= pend_next;
        end
        phase_reg <= phase_next;
    end

endmodule

`default_nettype wire

// ===== src/tlpm_queue.sv =====
// ----------------------------------------------------------------------------
// tlpm_queue: short FIFO between front and back
// Holds level and clear-marker work items so intake and evaluation stall independently.
// ----------------------------------------------------------------------------
`default_nettype none

module tlpm_queue #(
    parameter int DEPTH = tlpm_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               push_valid,
    output logic                    push_ready,
    input  wire tlpm_pkg::item_t    push_item,
    output logic                    pop_valid,
    input  wire logic               pop_ready,
    output tlpm_pkg::item_t         pop_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    tlpm_pkg::item_t   mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              do_push, do_pop;

    assign push_ready = (cnt_reg != CNT_FULL);
    assign pop_valid  = (cnt_reg != '0);
    assign pop_item   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// ===== src/tlpm_back.sv =====
// ----------------------------------------------------------------------------
// tlpm_back: phase decision and fill percent
// Takes one queued item at a time, picks the next phase, keeps the set-down
// error counter and runs a bit-serial restoring divide for the fill percent.
// ----------------------------------------------------------------------------
`default_nettype none

module tlpm_back (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire tlpm_pkg::cfg_t                 cfg,
    input  wire logic                           pop_valid,
    output logic                                pop_ready,
    input  wire tlpm_pkg::item_t                pop_item,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [tlpm_pkg::LEVEL_W-1:0]        m_level,
    output logic [tlpm_pkg::PHASE_W-1:0]        m_next_phase,
    output logic [tlpm_pkg::PCT_W-1:0]          m_fill_percent,
    output logic                                m_error_flag
);

    localparam int CFG_W  = tlpm_pkg::CFG_W;
    localparam int PCT_W  = tlpm_pkg::PCT_W;
    localparam int STEP_W = $clog2(PCT_W + 1);
    localparam logic [STEP_W-1:0] STEPS = STEP_W'(PCT_W);

    tlpm_pkg::back_state_t          state_reg, state_next;
    logic [tlpm_pkg::ERR_W-1:0]     err_reg, err_next;
    logic [tlpm_pkg::LEVEL_W-1:0]   level_reg, level_next;
    tlpm_pkg::phase_t               phase_reg, phase_next;
    logic [PCT_W-1:0]               num_reg, num_next;
    logic [CFG_W-1:0]               rem_reg, rem_next;
    logic [STEP_W-1:0]              step_reg, step_next;

    logic                           take, is_block, active, need_div;
    logic [CFG_W:0]                 o2_thr, circ_thr;
    logic                           ge_o2, ge_circ;
    logic [CFG_W-1:0]               above_min;
    logic [CFG_W:0]                 trial;
    logic                           trial_ge;
    logic                           div_last;

    // Threshold compares on the queued level
    always_comb begin
        o2_thr    = {1'b0, cfg.o2_height} + {1'b0, cfg.min_pressure};
        circ_thr  = {1'b0, cfg.circ_height} + {1'b0, cfg.min_pressure};
        ge_o2     = {1'b0, pop_item.level} >= o2_thr;
        ge_circ   = {1'b0, pop_item.level} >= circ_thr;
        above_min = pop_item.level - cfg.min_pressure;
        active    = cfg.sensor_enable && (pop_item.phase != tlpm_pkg::PH_PUMP_OFF)
                    && (pop_item.phase != tlpm_pkg::PH_MUD);
        need_div  = active && (cfg.o2_height != '0)
                    && (pop_item.level > cfg.min_pressure);
    end

    // One restoring divide step
    always_comb begin
        trial    = {rem_reg, num_reg[PCT_W-1]};
        trial_ge = trial >= {1'b0, cfg.o2_height};
        div_last = (step_reg == STEP_W'(1));
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            tlpm_pkg::BK_IDLE: begin
                if (pop_valid && !pop_item.is_clear) begin
                    state_next = need_div ? tlpm_pkg::BK_DIV : tlpm_pkg::BK_OUT;
                end
            end
            tlpm_pkg::BK_DIV: begin
                if (div_last) begin
                    state_next = tlpm_pkg::BK_OUT;
                end
            end
            tlpm_pkg::BK_OUT: begin
                if (m_ready) begin
                    state_next = tlpm_pkg::BK_IDLE;
                end
            end
            default: state_next = tlpm_pkg::BK_IDLE;
        endcase
    end

    // Handshake outputs
    always_comb begin
        pop_ready      = (state_reg == tlpm_pkg::BK_IDLE);
        m_valid        = (state_reg == tlpm_pkg::BK_OUT);
        m_level        = level_reg;
        m_next_phase   = phase_reg;
        m_fill_percent = num_reg;
        m_error_flag   = (err_reg >= tlpm_pkg::ERR_LIMIT);
    end

    assign take     = pop_valid && pop_ready;
    assign is_block = take && !pop_item.is_clear;

    // Datapath: decision on take, divide steps afterwards
    always_comb begin
        err_next   = err_reg;
        level_next = level_reg;
        phase_next = phase_reg;
        num_next   = num_reg;
        rem_next   = rem_reg;
        step_next  = step_reg;
        if (take && pop_item.is_clear) begin
            err_next = '0;
        end else if (is_block) begin
            level_next = pop_item.level;
            phase_next = pop_item.phase;
            rem_next   = '0;
            step_next  = STEPS;
            num_next   = need_div ? PCT_W'(above_min) * PCT_W'(tlpm_pkg::PCT_SCALE) : '0;
            if (active) begin
                unique case (pop_item.phase)
                    tlpm_pkg::PH_CIRC: begin
                        if (ge_o2) begin
                            phase_next = tlpm_pkg::PH_SET_DOWN;
                            if (err_reg != tlpm_pkg::ERR_MAX) begin
                                err_next = err_reg + 1'b1;
                            end
                        end else begin
                            err_next   = '0;
                            phase_next = ge_circ ? tlpm_pkg::PH_AIR : tlpm_pkg::PH_CIRC;
                        end
                    end
                    tlpm_pkg::PH_AIR: begin
                        phase_next = ge_o2 ? tlpm_pkg::PH_SET_DOWN : tlpm_pkg::PH_AIR;
                    end
                    tlpm_pkg::PH_ZONE: begin
                        if (ge_o2) begin
                            phase_next = tlpm_pkg::PH_SET_DOWN;
                        end else begin
                            phase_next = ge_circ ? tlpm_pkg::PH_AIR : tlpm_pkg::PH_CIRC;
                        end
                    end
                    default: phase_next = pop_item.phase;
                endcase
            end
        end else if (state_reg == tlpm_pkg::BK_DIV) begin
            rem_next  = trial_ge ? CFG_W'(trial - {1'b0, cfg.o2_height}) : trial[CFG_W-1:0];
            num_next  = {num_reg[PCT_W-2:0], trial_ge};
            step_next = step_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tlpm_pkg::BK_IDLE;
            err_reg   <= '0;
        end else begin
            state_reg <= state_next;
            err_reg   <= err_next;
        end
        level_reg <= level_next;
        phase_reg <= phase_next;
        num_reg   <= num_next;
        rem_reg   <= rem_next;
        step_reg  <= step_next;
    end

endmodule

`default_nettype wire

// ===== src/tank_level_phase_monitor.sv =====
// ----------------------------------------------------------------------------
// tank_level_phase_monitor: tank level averaging and treatment phase choice
// Averages blocks of calibrated pressure samples into a level, picks the
// next treatment phase and reports the fill percent relative to O2 height.
//
// Usage:
//   s_* carries one transaction per converter sample (tuser = clear flag).
//   Only the last sample of each block yields one m_* transaction; clear
//   transactions and the other samples yield none.
//   cfg_* writes the registers (index 0..4); cfg_ready is always high. The
//   user makes writes only while the block is idle; the block does not enforce it.
//   Throughput: samples are taken one per cycle while the queue has room,
//   pausing at each block end while the level is pushed. The evaluator
//   takes no new item until its result is taken, so once the queue fills
//   it paces the intake. After the last sample of a block is taken, its
//   level is pushed into the queue, taken into the evaluator and run
//   through 17 steps of the bit-serial percent divider before m_tvalid
//   rises; the divider is skipped when the sensor is inactive, the O2
//   height is zero or the level is not above the minimum pressure.
//   When m_tready is low the result holds; samples keep being taken until
//   the QUEUE_DEPTH-entry queue between intake and evaluator fills.
//   Reset clears registers, sample count, block sum and error counter.
// ----------------------------------------------------------------------------
`default_nettype none

module tank_level_phase_monitor #(
    parameter int BLOCK_SAMPLES = tlpm_pkg::BLOCK_SAMPLES_DEF,
    parameter int QUEUE_DEPTH   = tlpm_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // sample channel
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [15:0]                       s_tdata,  // raw_sample[11:0], phase[14:12]
    input  wire logic [0:0]                        s_tuser,  // func
    // result channel
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [31:0]                            m_tdata,  // level[9:0], next_phase[12:10],
                                                             // fill_percent[29:13], error_flag[30]
    // register write channel
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [tlpm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [tlpm_pkg::CFG_W-1:0]        cfg_data
);

    tlpm_pkg::cfg_t    cfg_reg, cfg_next;
    logic              push_valid, push_ready, pop_valid, pop_ready;
    tlpm_pkg::item_t   push_item, pop_item;
    logic [tlpm_pkg::LEVEL_W-1:0] out_level;
    logic [tlpm_pkg::PHASE_W-1:0] out_phase;
    logic [tlpm_pkg::PCT_W-1:0]   out_pct;
    logic                         out_err;

    // Register file
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                tlpm_pkg::REG_CAL_OFFSET:    cfg_next.cal_offset    = cfg_data;
                tlpm_pkg::REG_O2_HEIGHT:     cfg_next.o2_height     = cfg_data;
                tlpm_pkg::REG_CIRC_HEIGHT:   cfg_next.circ_height   = cfg_data;
                tlpm_pkg::REG_MIN_PRESSURE:  cfg_next.min_pressure  = cfg_data;
                tlpm_pkg::REG_SENSOR_ENABLE: cfg_next.sensor_enable = cfg_data[0];
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Intake and block averaging
    tlpm_front #(
        .BLOCK_SAMPLES (BLOCK_SAMPLES)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_func     (s_tuser[0]),
        .s_raw      (s_tdata[11:0]),
        .s_phase    (s_tdata[14:12]),
        .cal_offset (cfg_reg.cal_offset),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    // Decoupling queue
    tlpm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    // Evaluation
    tlpm_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .pop_valid      (pop_valid),
        .pop_ready      (pop_ready),
        .pop_item       (pop_item),
        .m_valid        (m_tvalid),
        .m_ready        (m_tready),
        .m_level        (out_level),
        .m_next_phase   (out_phase),
        .m_fill_percent (out_pct),
        .m_error_flag   (out_err)
    );

    assign m_tdata = {1'b0, out_err, out_pct, out_phase, out_level};

endmodule

`default_nettype wire
